// ----- src/uat_pkg.sv -----
// shared types and constants of the unsorted array table
`default_nettype none
package uat_pkg;

  localparam int unsigned CAPACITY_DEF = 512;
  localparam int unsigned OPCODE_W     = 3;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_OUT_W  = 10;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT     = 3'd0,
    OP_DELETE     = 3'd1,
    OP_RETRIEVE   = 3'd2,
    OP_MAKE_EMPTY = 3'd3,
    OP_RESET_CUR  = 3'd4,
    OP_GET_NEXT   = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NO_MORE = 2'd3
  } status_e;

endpackage
`default_nettype wire

// ----- src/uat_ifs.sv -----
// request and result channel interfaces of the unsorted array table
`default_nettype none
interface uat_in_if import uat_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [DATA_W-1:0]   key_value;

  modport source (output valid, output opcode, output key_value, input ready);
  modport sink   (input valid, input opcode, input key_value, output ready);
endinterface

interface uat_out_if import uat_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [DATA_W-1:0]   item_value;
  logic                       found;
  logic [STATUS_W-1:0]        status;
  logic [COUNT_OUT_W-1:0]     item_count;
  logic                       at_last;
  logic signed [DATA_W-1:0]   total;

  modport source (output valid, output item_value, output found, output status,
                  output item_count, output at_last, output total, input ready);
  modport sink   (input valid, input item_value, input found, input status,
                  input item_count, input at_last, input total, output ready);
endinterface
`default_nettype wire

// ----- src/uat_store.sv -----
// entry memory, one write port and one registered read port
`default_nettype none
module uat_store import uat_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- src/uat_ctrl.sv -----
// operation sequencer with the shared scan compare and count, cursor and sum
`default_nettype none
module uat_ctrl import uat_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  uat_in_if.sink                 in_i,
  uat_out_if.source              out_o,
  output logic                   we_o,
  output logic      [AW-1:0]     waddr_o,
  output logic      [DATA_W-1:0] wdata_o,
  output logic                   re_o,
  output logic      [AW-1:0]     raddr_o,
  input  wire logic [DATA_W-1:0] rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_NEXT_RD,
    S_DONE
  } state_e;

  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  state_e                 state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          cursor_q, cursor_d;
  logic [DATA_W-1:0]      sum_q, sum_d;
  logic [OPCODE_W-1:0]    op_q, op_d;
  logic [DATA_W-1:0]      key_q, key_d;
  logic [CW-1:0]          scan_q, scan_d;
  logic                   chk_vld_q, chk_vld_d;
  logic [AW-1:0]          chk_idx_q, chk_idx_d;
  logic [AW-1:0]          hit_idx_q, hit_idx_d;
  logic [DATA_W-1:0]      res_value_q, res_value_d;
  logic                   res_found_q, res_found_d;
  status_e                res_status_q, res_status_d;
  logic                   out_vld_q, out_vld_d;
  logic [DATA_W-1:0]      out_value_q, out_value_d;
  logic                   out_found_q, out_found_d;
  logic [STATUS_W-1:0]    out_status_q, out_status_d;
  logic [COUNT_OUT_W-1:0] out_count_q, out_count_d;
  logic                   out_last_q, out_last_d;
  logic [DATA_W-1:0]      out_total_q, out_total_d;
  logic [CW-1:0]          count_m1;
  logic                   slot_free;

  assign count_m1  = count_q - CW'(1);
  assign slot_free = !out_vld_q || out_o.ready;

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_vld_q;
  assign out_o.item_value = out_value_q;
  assign out_o.found      = out_found_q;
  assign out_o.status     = out_status_q;
  assign out_o.item_count = out_count_q;
  assign out_o.at_last    = out_last_q;
  assign out_o.total      = out_total_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cursor_d     = cursor_q;
    sum_d        = sum_q;
    op_d         = op_q;
    key_d        = key_q;
    scan_d       = scan_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    hit_idx_d    = hit_idx_q;
    res_value_d  = res_value_q;
    res_found_d  = res_found_q;
    res_status_d = res_status_q;
    out_vld_d    = out_vld_q && !out_o.ready;
    out_value_d  = out_value_q;
    out_found_d  = out_found_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;
    out_total_d  = out_total_q;
    we_o         = 1'b0;
    waddr_o      = count_q[AW-1:0];
    wdata_o      = in_i.key_value;
    re_o         = 1'b0;
    raddr_o      = cursor_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d         = in_i.opcode;
          key_d        = in_i.key_value;
          res_value_d  = '0;
          res_found_d  = 1'b0;
          res_status_d = ST_OK;
          scan_d       = '0;
          state_d      = S_DONE;
          case (op_e'(in_i.opcode))
            OP_INSERT: begin
              if (count_q >= CAP_CNT) begin
                res_status_d = ST_FULL;
              end else begin
                we_o    = 1'b1;
                count_d = count_q + CW'(1);
                sum_d   = sum_q + in_i.key_value;
              end
            end
            OP_DELETE: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_RETRIEVE: begin
              state_d = S_SCAN;
            end
            OP_MAKE_EMPTY: begin
              count_d = '0;
              sum_d   = '0;
            end
            OP_RESET_CUR: begin
              cursor_d = '0;
            end
            OP_GET_NEXT: begin
              if (cursor_q >= count_q) begin
                res_status_d = ST_NO_MORE;
              end else begin
                re_o    = 1'b1;
                state_d = S_NEXT_RD;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (chk_vld_q && (rdata_i == key_q)) begin
          if (op_e'(op_q) == OP_DELETE) begin
            hit_idx_d = chk_idx_q;
            state_d   = S_MOVE_RD;
          end else begin
            res_value_d = key_q;
            state_d     = S_DONE;
          end
          res_found_d = 1'b1;
        end else if (scan_q < count_q) begin
          re_o      = 1'b1;
          raddr_o   = scan_q[AW-1:0];
          scan_d    = scan_q + CW'(1);
          chk_vld_d = 1'b1;
          chk_idx_d = scan_q[AW-1:0];
        end else begin
          state_d = S_DONE;
        end
      end
      S_MOVE_RD: begin
        re_o    = 1'b1;
        raddr_o = count_m1[AW-1:0];
        state_d = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        we_o    = 1'b1;
        waddr_o = hit_idx_q;
        wdata_o = rdata_i;
        count_d = count_m1;
        sum_d   = sum_q - key_q;
        state_d = S_DONE;
      end
      S_NEXT_RD: begin
        res_value_d = rdata_i;
        cursor_d    = cursor_q + CW'(1);
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          out_vld_d    = 1'b1;
          out_value_d  = res_value_q;
          out_found_d  = res_found_q;
          out_status_d = res_status_q;
          out_count_d  = COUNT_OUT_W'(count_q);
          out_last_d   = (cursor_q >= count_q);
          out_total_d  = sum_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      cursor_q  <= '0;
      sum_q     <= '0;
      chk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cursor_q  <= cursor_d;
      sum_q     <= sum_d;
      chk_vld_q <= chk_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    scan_q       <= scan_d;
    chk_idx_q    <= chk_idx_d;
    hit_idx_q    <= hit_idx_d;
    res_value_q  <= res_value_d;
    res_found_q  <= res_found_d;
    res_status_q <= res_status_d;
    out_value_q  <= out_value_d;
    out_found_q  <= out_found_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
    out_total_q  <= out_total_d;
  end

endmodule
`default_nettype wire

// ----- src/unsorted_array_table_top.sv -----
// top level of the unsorted array table
// insert, make empty and reset cursor go straight to done; get next reads one
// entry unless at the end; retrieve and delete scan, one stored entry
// compared per cycle through the single memory read port
// a new word is taken once the previous result sits in the output register
// reset clears count, cursor, sum and control; table contents stay undefined
`default_nettype none
module unsorted_array_table_top import uat_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  uat_in_if.sink     in_i,
  uat_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;

  uat_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .out_o   (out_o),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .re_o    (re),
    .raddr_o (raddr),
    .rdata_i (rdata)
  );

  uat_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule
`default_nettype wire

// ----- verif/unsorted_array_table_top_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench of the unsorted array table, checked against a shadow copy of the table
module unsorted_array_table_top_tb;
  import uat_pkg::*;

  localparam int unsigned CAPACITY    = CAPACITY_DEF;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned TAIL_CYCLES = CAPACITY + 16;
  localparam int unsigned MIX_WORDS   = 40;

  typedef struct {
    logic [DATA_W-1:0]      item_value;
    logic                   found;
    status_e                status;
    logic [COUNT_OUT_W-1:0] item_count;
    logic                   at_last;
    logic [DATA_W-1:0]      total;
  } table_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  uat_in_if  req_if ();
  uat_out_if res_if ();

  unsorted_array_table_top #(.CAPACITY(CAPACITY)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if)
  );

  always #2 clk_i = ~clk_i;

  logic [DATA_W-1:0] shadow_entries [CAPACITY];
  int unsigned       shadow_count;
  int unsigned       shadow_cursor;
  logic [DATA_W-1:0] shadow_sum;
  table_result_t     expected_results [$];

  int unsigned error_count = 0;
  bit          tx_steady;
  bit          rx_steady;
  int unsigned tx_burst_left;
  int unsigned rx_hold_request;

  function automatic table_result_t shadow_apply(op_e op, logic [DATA_W-1:0] key);
    table_result_t r;
    int unsigned   idx;
    r.item_value = '0;
    r.found      = 1'b0;
    r.status     = ST_OK;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_entries[shadow_count] = key;
          shadow_count++;
          shadow_sum += key;
        end
      end
      OP_DELETE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          idx = 0;
          while (idx < shadow_count && shadow_entries[idx] != key) idx++;
          if (idx < shadow_count) begin
            r.found = 1'b1;
            shadow_sum -= shadow_entries[idx];
            shadow_count--;
            shadow_entries[idx] = shadow_entries[shadow_count];
          end
        end
      end
      OP_RETRIEVE: begin
        idx = 0;
        while (idx < shadow_count && shadow_entries[idx] != key) idx++;
        if (idx < shadow_count) begin
          r.found      = 1'b1;
          r.item_value = key;
        end
      end
      OP_MAKE_EMPTY: begin
        shadow_count = 0;
        shadow_sum   = '0;
      end
      OP_RESET_CUR: begin
        shadow_cursor = 0;
      end
      OP_GET_NEXT: begin
        if (shadow_cursor >= shadow_count) begin
          r.status = ST_NO_MORE;
        end else begin
          r.item_value = shadow_entries[shadow_cursor];
          shadow_cursor++;
        end
      end
      default: ;
    endcase
    r.item_count = COUNT_OUT_W'(shadow_count);
    r.at_last    = (shadow_cursor >= shadow_count);
    r.total      = shadow_sum;
    return r;
  endfunction

  // small values give duplicates, plus the extremes and full-range noise
  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = DATA_W'($urandom_range(0, 16)) - DATA_W'(8);
      4: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] pick_lookup_key();
    logic [DATA_W-1:0] v;
    if (shadow_count != 0 && $urandom_range(0, 9) < 6) v = shadow_entries[$urandom_range(0, shadow_count - 1)];
    else v = pick_value();
    return v;
  endfunction

  task automatic send_word(op_e op, logic [DATA_W-1:0] key);
    int unsigned gap;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 24);
      gap = tx_steady ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
        @(negedge clk_i);
        req_if.valid <= 1'b0;
      end
    end
    tx_burst_left--;
    @(negedge clk_i);
    req_if.valid     <= 1'b1;
    req_if.opcode    <= op;
    req_if.key_value <= key;
    do @(posedge clk_i); while (!req_if.ready);
    expected_results.push_back(shadow_apply(op, key));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    table_result_t oldest;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $error("result word with no expectation pending");
      end else begin
        oldest = expected_results.pop_front();
        if (res_if.item_value !== oldest.item_value) begin
          error_count++;
          $error("item_value: expected %0d, got %0d", $signed(oldest.item_value),
                 $signed(res_if.item_value));
        end
        if (res_if.found !== oldest.found) begin
          error_count++;
          $error("found: expected %0d, got %0d", oldest.found, res_if.found);
        end
        if (res_if.status !== oldest.status) begin
          error_count++;
          $error("status: expected %0d, got %0d", oldest.status, res_if.status);
        end
        if (res_if.item_count !== oldest.item_count) begin
          error_count++;
          $error("item_count: expected %0d, got %0d", oldest.item_count, res_if.item_count);
        end
        if (res_if.at_last !== oldest.at_last) begin
          error_count++;
          $error("at_last: expected %0d, got %0d", oldest.at_last, res_if.at_last);
        end
        if (res_if.total !== oldest.total) begin
          error_count++;
          $error("total: expected %0d, got %0d", $signed(oldest.total), $signed(res_if.total));
        end
      end
    end
  end

  initial begin : receiver
    int unsigned run_left;
    int unsigned hold_left;
    bit          stalling;
    run_left  = 0;
    hold_left = 0;
    stalling  = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_request != 0) begin
        hold_left       = rx_hold_request;
        rx_hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (rx_steady) begin
        res_if.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          stalling = !stalling;
          run_left = stalling ? $urandom_range(1, 6) : $urandom_range(1, 12);
        end
        run_left--;
        res_if.ready <= !stalling;
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("unsorted_array_table_top regression: fail");
    $finish;
  end

  task automatic test_empty_table();
    send_word(OP_DELETE, 32'h0000_0000);
    send_word(OP_RETRIEVE, 32'h0000_0000);
    send_word(OP_GET_NEXT, 32'hFFFF_FFFF);
  endtask

  // two maximum values wrap the sum
  task automatic test_insert_and_wrap();
    send_word(OP_INSERT, 32'h7FFF_FFFF);
    send_word(OP_INSERT, 32'h7FFF_FFFF);
    send_word(OP_INSERT, 32'h8000_0000);
    send_word(OP_INSERT, 32'h0000_0000);
    send_word(OP_INSERT, 32'hFFFF_FFFF);
    send_word(OP_RETRIEVE, 32'h8000_0000);
    send_word(OP_RETRIEVE, 32'h0000_0005);
  endtask

  // first match goes, last entry moves into its slot
  task automatic test_delete_moves_last();
    send_word(OP_DELETE, 32'h7FFF_FFFF);
    send_word(OP_DELETE, 32'h0001_2345);
  endtask

  // walk past the end, then shrink below the cursor
  task automatic test_cursor_walk();
    send_word(OP_RESET_CUR, 32'h5555_5555);
    repeat (5) send_word(OP_GET_NEXT, 32'hAAAA_AAAA);
    send_word(OP_DELETE, 32'h0000_0000);
    send_word(OP_GET_NEXT, 32'h0000_0000);
  endtask

  task automatic test_make_empty_keeps_cursor();
    send_word(OP_MAKE_EMPTY, 32'h0000_0000);
    send_word(OP_INSERT, 32'h0000_002A);
    send_word(OP_GET_NEXT, 32'h0000_0000);
    send_word(OP_RESET_CUR, 32'h0000_0000);
    send_word(OP_GET_NEXT, 32'h0000_0000);
  endtask

  task automatic test_backpressure();
    tx_steady       = 1'b1;
    rx_steady       = 1'b1;
    rx_hold_request = 300;
    repeat (30) begin
      if ($urandom_range(0, 1) != 0) send_word(OP_INSERT, pick_value());
      else send_word(OP_RETRIEVE, pick_lookup_key());
    end
    wait_idle();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_random_mix(int unsigned n_words);
    int unsigned sent;
    int unsigned steps;
    int unsigned roll;
    int unsigned ins;
    sent = 0;
    while (sent < n_words) begin
      if (sent % 50 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        send_word(OP_RESET_CUR, $urandom());
        steps = shadow_count + $urandom_range(0, 2);
        repeat (steps) send_word(OP_GET_NEXT, $urandom());
        sent += steps + 1;
      end else begin
        // keep the table small so scans stay short
        ins  = (shadow_count < 4) ? 60 : (shadow_count > 40) ? 15 : 35;
        roll = $urandom_range(0, 99);
        if (roll < ins) send_word(OP_INSERT, pick_value());
        else if (roll < ins + 25) send_word(OP_DELETE, pick_lookup_key());
        else if (roll < ins + 47) send_word(OP_RETRIEVE, pick_lookup_key());
        else if (roll < ins + 57) send_word(OP_GET_NEXT, $urandom());
        else if (roll < ins + 62) send_word(OP_RESET_CUR, $urandom());
        else if (roll < ins + 65) send_word(OP_MAKE_EMPTY, $urandom());
        else send_word(OP_RETRIEVE, pick_lookup_key());
        sent++;
      end
    end
    wait_idle();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_fill_to_capacity();
    send_word(OP_MAKE_EMPTY, $urandom());
    send_word(OP_RESET_CUR, $urandom());
    while (shadow_count < CAPACITY) send_word(OP_INSERT, pick_value());
    repeat (3) send_word(OP_INSERT, $urandom());
    send_word(OP_RETRIEVE, shadow_entries[CAPACITY-1]);
    send_word(OP_RETRIEVE, $urandom());
    repeat (4) send_word(OP_GET_NEXT, $urandom());
    repeat (10) begin
      if ($urandom_range(0, 1) != 0) send_word(OP_DELETE, pick_lookup_key());
      else send_word(OP_RETRIEVE, pick_lookup_key());
    end
    send_word(OP_DELETE, shadow_entries[shadow_count-1]);
    while (shadow_count < CAPACITY) send_word(OP_INSERT, pick_value());
    send_word(OP_INSERT, $urandom());
    send_word(OP_DELETE, $urandom());
    send_word(OP_MAKE_EMPTY, $urandom());
    send_word(OP_DELETE, $urandom());
    wait_idle();
  endtask

  initial begin
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.opcode    = OP_INSERT;
    req_if.key_value = '0;
    tx_steady        = 1'b0;
    rx_steady        = 1'b0;
    tx_burst_left    = 0;
    rx_hold_request  = 0;
    shadow_count     = 0;
    shadow_cursor    = 0;
    shadow_sum       = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_insert_and_wrap();
    test_delete_moves_last();
    test_cursor_walk();
    test_make_empty_keeps_cursor();
    wait_idle();
    test_backpressure();
    test_random_mix(MIX_WORDS);
    test_fill_to_capacity();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("unsorted_array_table_top regression: pass");
    end else begin
      $display("unsorted_array_table_top regression: fail");
    end
    $finish;
  end

endmodule
